// ===== rtl/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shelf rectangle placer package
// Field widths, register indexes, status codes and shared word types.
// ----------------------------------------------------------------------------
package srp_pkg;

   localparam int unsigned RECT_WIDTH        = 16;
   localparam int unsigned DIM_WIDTH         = 13;
   localparam int unsigned POS_WIDTH         = 12;
   localparam int unsigned PAGE_IDX_WIDTH    = 8;
   localparam int unsigned AREA_WIDTH        = 32;
   localparam int unsigned STATUS_WIDTH      = 2;
   localparam int unsigned CSR_INDEX_WIDTH   = 1;
   localparam int unsigned CSR_DATA_WIDTH    = 13;

   localparam int unsigned PAD_ALIGN         = 16;
   localparam int unsigned PAD_SHIFT         = $clog2(PAD_ALIGN);
   localparam int unsigned MAX_PAGES_DEFAULT = 256;

   localparam logic [DIM_WIDTH-1:0] PAGE_WIDTH_RESET  = DIM_WIDTH'(320);
   localparam logic [DIM_WIDTH-1:0] PAGE_HEIGHT_RESET = DIM_WIDTH'(256);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PAGE_WIDTH  = 1'b0,
      CSR_PAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_PLACED    = 2'd0,
      STATUS_BAD_WIDTH = 2'd1,
      STATUS_TOO_BIG   = 2'd2,
      STATUS_NO_PAGE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0] page_width;
      logic [DIM_WIDTH-1:0] page_height;
   } cfg_type;

   typedef struct packed {
      status_type                status;
      logic [PAGE_IDX_WIDTH-1:0] page_index;
      logic [POS_WIDTH-1:0]      pos_x;
      logic [POS_WIDTH-1:0]      pos_y;
      logic [DIM_WIDTH-1:0]      padded_width;
      logic [AREA_WIDTH-1:0]     used_area;
   } result_type;

endpackage

// ===== rtl/srp_req_if.sv =====
// ----------------------------------------------------------------------------
// Rectangle request channel
// Valid/ready channel carrying one rectangle word.
// ----------------------------------------------------------------------------
interface srp_req_if;
   logic                            valid;
   logic                            ready;
   logic [srp_pkg::RECT_WIDTH-1:0]  rect_width;
   logic [srp_pkg::RECT_WIDTH-1:0]  rect_height;

   modport source (output valid, output rect_width, output rect_height, input ready);
   modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

// ===== rtl/srp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Placement response channel
// Valid/ready channel carrying one placement result word.
// ----------------------------------------------------------------------------
interface srp_rsp_if;
   logic                                valid;
   logic                                ready;
   srp_pkg::status_type                 status;
   logic [srp_pkg::PAGE_IDX_WIDTH-1:0]  page_index;
   logic [srp_pkg::POS_WIDTH-1:0]       pos_x;
   logic [srp_pkg::POS_WIDTH-1:0]       pos_y;
   logic [srp_pkg::DIM_WIDTH-1:0]       padded_width;
   logic [srp_pkg::AREA_WIDTH-1:0]      used_area;

   modport source (output valid, output status, output page_index, output pos_x,
                   output pos_y, output padded_width, output used_area, input ready);
   modport sink   (input valid, input status, input page_index, input pos_x,
                   input pos_y, input padded_width, input used_area, output ready);
endinterface

// ===== rtl/srp_csr.sv =====
// ----------------------------------------------------------------------------
// Shelf placer configuration registers
// Page width and page height, written through a plain write port.
// ----------------------------------------------------------------------------
module srp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [srp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [srp_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output srp_pkg::cfg_type                      cfg
);
   import srp_pkg::*;

   logic [DIM_WIDTH-1:0] page_width_ff;
   logic [DIM_WIDTH-1:0] page_height_ff;
   logic [DIM_WIDTH-1:0] page_width_in;
   logic [DIM_WIDTH-1:0] page_height_in;

   always_comb begin
      page_width_in  = page_width_ff;
      page_height_in = page_height_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAGE_WIDTH:  page_width_in  = DIM_WIDTH'(csr_write_data);
            CSR_PAGE_HEIGHT: page_height_in = DIM_WIDTH'(csr_write_data);
            default:         page_width_in  = page_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_width_ff  <= PAGE_WIDTH_RESET;
         page_height_ff <= PAGE_HEIGHT_RESET;
      end else begin
         page_width_ff  <= page_width_in;
         page_height_ff <= page_height_in;
      end
   end

   assign cfg.page_width  = page_width_ff;
   assign cfg.page_height = page_height_ff;

endmodule

// ===== rtl/srp_placer.sv =====
// ----------------------------------------------------------------------------
// Shelf placement stage
// Pads the width, checks the rectangle, chooses shelf or page and keeps the
// shelf, page and area state.
// ----------------------------------------------------------------------------
module srp_placer #(
   parameter int unsigned MAX_PAGES = srp_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [srp_pkg::RECT_WIDTH-1:0]  rect_width,
   input  logic [srp_pkg::RECT_WIDTH-1:0]  rect_height,
   input  srp_pkg::cfg_type                cfg,
   output srp_pkg::result_type             result
);
   import srp_pkg::*;

   localparam int unsigned PageCountWidth = $clog2(MAX_PAGES + 1);
   localparam logic [PageCountWidth-1:0] PageLimit = PageCountWidth'(MAX_PAGES);

   logic [DIM_WIDTH-1:0]      shelf_left_ff,   shelf_left_in;
   logic [DIM_WIDTH-1:0]      shelf_top_ff,    shelf_top_in;
   logic [DIM_WIDTH-1:0]      shelf_height_ff, shelf_height_in;
   logic [PageCountWidth-1:0] pages_open_ff,   pages_open_in;
   logic [AREA_WIDTH-1:0]     area_total_ff,   area_total_in;

   logic [RECT_WIDTH:0]       width_sum;
   logic [RECT_WIDTH:0]       padded_full;
   logic [DIM_WIDTH-1:0]      padded;
   logic [DIM_WIDTH-1:0]      height;
   logic [DIM_WIDTH-1:0]      cur_x;
   logic [DIM_WIDTH-1:0]      place_x;
   logic [DIM_WIDTH:0]        place_y;
   logic [DIM_WIDTH:0]        next_top;
   logic [2*DIM_WIDTH-1:0]    rect_area;
   logic [PageCountWidth-1:0] page_num;
   logic                      bad_width;
   logic                      too_big;
   logic                      shelf_empty;
   logic                      have_page;
   logic                      fit_cur;
   logic                      fit_next;
   logic                      page_full;
   logic                      placed;
   status_type                status;

   assign width_sum   = {1'b0, rect_width} + (RECT_WIDTH + 1)'(PAD_ALIGN - 1);
   assign padded_full = {width_sum[RECT_WIDTH:PAD_SHIFT], PAD_SHIFT'(0)};
   assign padded      = padded_full[DIM_WIDTH-1:0];
   assign height      = rect_height[DIM_WIDTH-1:0];

   assign bad_width = cfg.page_width[PAD_SHIFT-1:0] != '0;
   assign too_big   = (padded_full > (RECT_WIDTH + 1)'(cfg.page_width))
                   || (rect_height > RECT_WIDTH'(cfg.page_height));

   assign shelf_empty = shelf_height_ff == '0;
   assign have_page   = pages_open_ff != '0;
   assign page_full   = pages_open_ff >= PageLimit;
   assign cur_x       = shelf_empty ? '0 : shelf_left_ff;
   assign next_top    = {1'b0, shelf_top_ff} + {1'b0, shelf_height_ff};

   assign fit_cur = have_page
                 && ({1'b0, cur_x} + {1'b0, padded} <= {1'b0, cfg.page_width})
                 && ({1'b0, shelf_top_ff} + {1'b0, height} <= {1'b0, cfg.page_height})
                 && (shelf_empty || height <= shelf_height_ff);
   assign fit_next = have_page
                  && ({1'b0, next_top} + {2'b0, height} <= {2'b0, cfg.page_height});

   assign rect_area = padded * height;

   always_comb begin
      shelf_left_in   = shelf_left_ff;
      shelf_top_in    = shelf_top_ff;
      shelf_height_in = shelf_height_ff;
      pages_open_in   = pages_open_ff;
      area_total_in   = area_total_ff;
      place_x         = '0;
      place_y         = '0;
      placed          = 1'b0;
      priority if (bad_width) begin
         status = STATUS_BAD_WIDTH;
      end else if (too_big) begin
         status = STATUS_TOO_BIG;
      end else if (fit_cur) begin
         status  = STATUS_PLACED;
         placed  = 1'b1;
         place_x = cur_x;
         place_y = {1'b0, shelf_top_ff};
         if (shelf_empty) begin
            shelf_height_in = height;
         end
      end else if (fit_next) begin
         status          = STATUS_PLACED;
         placed          = 1'b1;
         place_y         = next_top;
         shelf_top_in    = next_top[DIM_WIDTH-1:0];
         shelf_height_in = height;
      end else if (page_full) begin
         status = STATUS_NO_PAGE;
      end else begin
         status          = STATUS_PLACED;
         placed          = 1'b1;
         pages_open_in   = pages_open_ff + 1'b1;
         shelf_top_in    = '0;
         shelf_height_in = height;
      end
      if (placed) begin
         shelf_left_in = place_x + padded;
         area_total_in = area_total_ff + AREA_WIDTH'(rect_area);
      end
   end

   assign page_num = pages_open_in - 1'b1;

   assign result.status       = status;
   assign result.page_index   = placed ? PAGE_IDX_WIDTH'(page_num) : '0;
   assign result.pos_x        = place_x[POS_WIDTH-1:0];
   assign result.pos_y        = place_y[POS_WIDTH-1:0];
   assign result.padded_width = placed ? padded : '0;
   assign result.used_area    = area_total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         shelf_left_ff   <= '0;
         shelf_top_ff    <= '0;
         shelf_height_ff <= '0;
         pages_open_ff   <= '0;
         area_total_ff   <= '0;
      end else if (step) begin
         shelf_left_ff   <= shelf_left_in;
         shelf_top_ff    <= shelf_top_in;
         shelf_height_ff <= shelf_height_in;
         pages_open_ff   <= pages_open_in;
         area_total_ff   <= area_total_in;
      end
   end

   a_page_bound: assert property (@(posedge clock) disable iff (reset)
      pages_open_ff <= PageLimit)
      else $error("page count beyond limit");

   a_shelf_needs_page: assert property (@(posedge clock) disable iff (reset)
      shelf_height_ff != '0 |-> pages_open_ff != '0)
      else $error("open shelf without a page");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      step && !placed |=> $stable(area_total_ff) && $stable(pages_open_ff)
                          && $stable(shelf_top_ff) && $stable(shelf_height_ff)
                          && $stable(shelf_left_ff))
      else $error("error word changed placer state");

   a_area_adds: assert property (@(posedge clock) disable iff (reset)
      step && placed |=>
         area_total_ff == $past(area_total_ff) + AREA_WIDTH'($past(rect_area)))
      else $error("area total not advanced by placed area");

endmodule

// ===== rtl/shelf_rect_placer.sv =====
// ----------------------------------------------------------------------------
// Shelf rectangle placer
// Packs padded rectangles onto shelves of fixed-size pages.
// ----------------------------------------------------------------------------
// Takes one rectangle word per clock while the response side takes words,
// and returns one result word for each, in order, through the input
// register and then the result register. The shelf, page and area state
// is updated in the placement stage as the word moves to the result
// register, so the next word sees it straight away and the sustained rate
// is one word per cycle while the response side takes words. Errors return
// status with zero position and leave all state untouched. Configuration
// writes must only occur while no word is in flight.
module shelf_rect_placer #(
   parameter int unsigned MAX_PAGES = srp_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   srp_req_if.sink                              req_bus,
   srp_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_en,
   input  logic [srp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [srp_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import srp_pkg::*;

   logic                  in_valid_ff,  in_valid_in;
   logic [RECT_WIDTH-1:0] in_width_ff;
   logic [RECT_WIDTH-1:0] in_height_ff;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_word_ff;
   result_type            place_word;
   cfg_type               cfg;
   logic                  advance;
   logic                  take_req;

   srp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   srp_placer #(
      .MAX_PAGES (MAX_PAGES)
   ) u_placer (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rect_width  (in_width_ff),
      .rect_height (in_height_ff),
      .cfg         (cfg),
      .result      (place_word)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take_req      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_width_ff  <= req_bus.rect_width;
         in_height_ff <= req_bus.rect_height;
      end
      if (advance) begin
         out_word_ff <= place_word;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_word_ff.status;
   assign rsp_bus.page_index   = out_word_ff.page_index;
   assign rsp_bus.pos_x        = out_word_ff.pos_x;
   assign rsp_bus.pos_y        = out_word_ff.pos_y;
   assign rsp_bus.padded_width = out_word_ff.padded_width;
   assign rsp_bus.used_area    = out_word_ff.used_area;

endmodule
